/* rtl/hsv_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsv_pkg
// Shared constants and types for the RGB to HSV converter pipeline.
// ----------------------------------------------------------------------------
package hsv_pkg;

    localparam int CHANNEL_BITS_DEF = 8;

    // hue in 1/64 degree
    localparam int HUE_W      = 15;
    localparam int HUE_Q_W    = 12;
    localparam int HUE_SECTOR = 3840;
    localparam int HUE_FULL   = 23040;

    typedef enum logic [1:0] {
        SECT_RED,
        SECT_GREEN,
        SECT_BLUE
    } sector_t;

    typedef struct packed {
        sector_t sector;
        logic    neg;
        logic    achrom;
    } hsv_ctl_t;

endpackage

/* rtl/hsv_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsv_front
// Two register stages: max/min and sector pick, then delta, hue difference
// magnitude and the scaled dividends for saturation and hue.
// ----------------------------------------------------------------------------
module hsv_front #(
    parameter int CHANNEL_BITS = hsv_pkg::CHANNEL_BITS_DEF
) (
    input  logic                                        aclk,
    input  logic                                        aresetn,
    input  logic                                        en,
    input  logic                                        in_valid,
    input  logic [CHANNEL_BITS-1:0]                     red,
    input  logic [CHANNEL_BITS-1:0]                     green,
    input  logic [CHANNEL_BITS-1:0]                     blue,
    output logic                                        out_valid,
    output logic [CHANNEL_BITS-1:0]                     hi,
    output logic [CHANNEL_BITS-1:0]                     delta,
    output logic [2*CHANNEL_BITS-1:0]                   sat_num,
    output logic [CHANNEL_BITS+hsv_pkg::HUE_Q_W-1:0]    hue_num,
    output hsv_pkg::hsv_ctl_t                           ctl
);
    import hsv_pkg::*;

    localparam int CB = CHANNEL_BITS;
    localparam int HN = CB + HUE_Q_W;

    // stage A
    logic [CB-1:0] hi_next, lo_next, p_next, q_next;
    sector_t       sector_next;
    logic          valid_a_reg;
    logic [CB-1:0] hi_a_reg, lo_a_reg, p_a_reg, q_a_reg;
    sector_t       sector_a_reg;

    // stage B
    logic [CB-1:0] delta_next, absdiff_next;
    logic          neg_next;
    logic [2*CB-1:0] sat_num_next;
    logic [HN-1:0] hue_num_next;
    logic          valid_b_reg;
    logic [CB-1:0] hi_b_reg, delta_b_reg;
    logic [2*CB-1:0] sat_num_b_reg;
    logic [HN-1:0] hue_num_b_reg;
    hsv_ctl_t      ctl_b_reg;

    always_comb begin
        hi_next = (red > green) ? red : green;
        lo_next = (red < green) ? red : green;
        if (blue > hi_next) begin
            hi_next = blue;
        end
        if (blue < lo_next) begin
            lo_next = blue;
        end
        if (red >= green && red >= blue) begin
            sector_next = SECT_RED;
            p_next      = green;
            q_next      = blue;
        end else if (green >= blue) begin
            sector_next = SECT_GREEN;
            p_next      = blue;
            q_next      = red;
        end else begin
            sector_next = SECT_BLUE;
            p_next      = red;
            q_next      = green;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_a_reg <= 1'b0;
        end else if (en) begin
            valid_a_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            hi_a_reg     <= hi_next;
            lo_a_reg     <= lo_next;
            p_a_reg      <= p_next;
            q_a_reg      <= q_next;
            sector_a_reg <= sector_next;
        end
    end

    always_comb begin
        delta_next   = hi_a_reg - lo_a_reg;
        neg_next     = p_a_reg < q_a_reg;
        absdiff_next = neg_next ? (q_a_reg - p_a_reg) : (p_a_reg - q_a_reg);
        // full*delta = (delta << CB) - delta
        sat_num_next = ({delta_next, {CB{1'b0}}}) - (2*CB)'(delta_next);
        // 3840*x = (x << 12) - (x << 8)
        hue_num_next = ({absdiff_next, 12'b0}) - (HN'(absdiff_next) << 8);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_b_reg <= 1'b0;
        end else if (en) begin
            valid_b_reg <= valid_a_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            hi_b_reg         <= hi_a_reg;
            delta_b_reg      <= delta_next;
            sat_num_b_reg    <= sat_num_next;
            hue_num_b_reg    <= hue_num_next;
            ctl_b_reg.sector <= sector_a_reg;
            ctl_b_reg.neg    <= neg_next;
            ctl_b_reg.achrom <= (delta_next == '0);
        end
    end

    assign out_valid = valid_b_reg;
    assign hi        = hi_b_reg;
    assign delta     = delta_b_reg;
    assign sat_num   = sat_num_b_reg;
    assign hue_num   = hue_num_b_reg;
    assign ctl       = ctl_b_reg;

endmodule

/* rtl/hsv_divider.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsv_divider
// Pipelined restoring divider, one quotient bit per register stage.
// The quotient must fit in QUO_W bits. A sideband word travels alongside.
// ----------------------------------------------------------------------------
module hsv_divider #(
    parameter int NUM_W  = 16,
    parameter int DEN_W  = 8,
    parameter int QUO_W  = 12,
    parameter int SIDE_W = 4
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              en,
    input  logic              in_valid,
    input  logic [NUM_W-1:0]  num,
    input  logic [DEN_W-1:0]  den,
    input  logic [SIDE_W-1:0] side_in,
    output logic              out_valid,
    output logic [QUO_W-1:0]  quo,
    output logic [SIDE_W-1:0] side_out
);
    localparam int CMP_W = DEN_W + QUO_W;

    logic              valid_reg [QUO_W];
    logic [QUO_W-1:0]  quo_reg   [QUO_W];
    logic [SIDE_W-1:0] side_reg  [QUO_W];
    logic [CMP_W-1:0]  rem_reg   [QUO_W-1];
    logic [DEN_W-1:0]  den_reg   [QUO_W-1];

    for (genvar k = 0; k < QUO_W; k++) begin : g_stage
        localparam int B = QUO_W - 1 - k;

        logic              valid_in;
        logic [CMP_W-1:0]  rem_in;
        logic [DEN_W-1:0]  den_in;
        logic [QUO_W-1:0]  quo_in;
        logic [SIDE_W-1:0] side_in_k;
        logic [CMP_W-1:0]  trial;
        logic              ge;
        logic [CMP_W-1:0]  rem_next;
        logic [QUO_W-1:0]  quo_next;

        if (k == 0) begin : g_first
            assign valid_in  = in_valid;
            assign rem_in    = CMP_W'(num);
            assign den_in    = den;
            assign quo_in    = '0;
            assign side_in_k = side_in;
        end else begin : g_rest
            assign valid_in  = valid_reg[k-1];
            assign rem_in    = rem_reg[k-1];
            assign den_in    = den_reg[k-1];
            assign quo_in    = quo_reg[k-1];
            assign side_in_k = side_reg[k-1];
        end

        always_comb begin
            trial       = CMP_W'(den_in) << B;
            ge          = rem_in >= trial;
            rem_next    = ge ? (rem_in - trial) : rem_in;
            quo_next    = quo_in;
            quo_next[B] = ge;
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                valid_reg[k] <= 1'b0;
            end else if (en) begin
                valid_reg[k] <= valid_in;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                quo_reg[k]  <= quo_next;
                side_reg[k] <= side_in_k;
            end
        end

        if (k < QUO_W - 1) begin : g_carry
            always_ff @(posedge aclk) begin
                if (en) begin
                    rem_reg[k] <= rem_next;
                    den_reg[k] <= den_in;
                end
            end
        end
    end

    assign out_valid = valid_reg[QUO_W-1];
    assign quo       = quo_reg[QUO_W-1];
    assign side_out  = side_reg[QUO_W-1];

endmodule

/* rtl/hsv_post.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsv_post
// Output stage: sector base plus signed hue offset with wrap, achromatic
// override, and the result register that drives the output channel.
// ----------------------------------------------------------------------------
module hsv_post #(
    parameter int CHANNEL_BITS = hsv_pkg::CHANNEL_BITS_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           en,
    input  logic                           in_valid,
    input  logic [hsv_pkg::HUE_Q_W-1:0]    hue_q,
    input  logic [CHANNEL_BITS-1:0]        sat_q,
    input  logic [CHANNEL_BITS-1:0]        hi,
    input  hsv_pkg::hsv_ctl_t              ctl,
    output logic                           out_valid,
    output logic [hsv_pkg::HUE_W-1:0]      hue,
    output logic [CHANNEL_BITS-1:0]        saturation,
    output logic [CHANNEL_BITS-1:0]        brightness,
    output logic                           achromatic
);
    import hsv_pkg::*;

    localparam int SW = HUE_W + 2;

    logic [HUE_W-1:0]        base;
    logic [SW-1:0]           hue_s;
    logic [HUE_W-1:0]        hue_next;
    logic [CHANNEL_BITS-1:0] sat_next;

    logic                    valid_reg;
    logic [HUE_W-1:0]        hue_reg;
    logic [CHANNEL_BITS-1:0] sat_reg;
    logic [CHANNEL_BITS-1:0] bright_reg;
    logic                    achrom_reg;

    always_comb begin
        case (ctl.sector)
            SECT_RED:   base = '0;
            SECT_GREEN: base = HUE_W'(2 * HUE_SECTOR);
            SECT_BLUE:  base = HUE_W'(4 * HUE_SECTOR);
            default:    base = '0;
        endcase
        hue_s = ctl.neg ? (SW'(base) - SW'(hue_q)) : (SW'(base) + SW'(hue_q));
        if (hue_s[SW-1]) begin
            hue_s = hue_s + SW'(HUE_FULL);
        end
        hue_next = ctl.achrom ? '0 : hue_s[HUE_W-1:0];
        sat_next = ctl.achrom ? '0 : sat_q;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            hue_reg    <= hue_next;
            sat_reg    <= sat_next;
            bright_reg <= hi;
            achrom_reg <= ctl.achrom;
        end
    end

    assign out_valid  = valid_reg;
    assign hue        = hue_reg;
    assign saturation = sat_reg;
    assign brightness = bright_reg;
    assign achromatic = achrom_reg;

endmodule

/* rtl/rgb_to_hsv_converter_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgb_to_hsv_converter_unit
// RGB pixel to HSV pixel converter, fully pipelined.
// ----------------------------------------------------------------------------
// Input channel s_*: one RGB word (s_red, s_green, s_blue) per handshake.
// Output channel m_*: one HSV word per input word, in order: m_hue in
// 1/64 degree, m_saturation, m_brightness (largest channel), m_achromatic.
// Stages: two front stages, one divider stage per quotient bit, one output
// stage. Throughput: one word per cycle while m_ready is high or m_valid
// low; saturation and hue use two restoring dividers side by side, each
// retiring one quotient bit per stage.
// Reset clears all valid bits; the pipeline comes up empty.
// When the receiver stalls (m_ready low with m_valid high) the whole
// pipeline holds, and s_ready drops in the same cycle; nothing is lost
// or repeated. s_ready stays high while the output register is empty.
// ----------------------------------------------------------------------------
module rgb_to_hsv_converter_unit #(
    parameter int CHANNEL_BITS = hsv_pkg::CHANNEL_BITS_DEF
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic [CHANNEL_BITS-1:0]     s_red,
    input  logic [CHANNEL_BITS-1:0]     s_green,
    input  logic [CHANNEL_BITS-1:0]     s_blue,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic [hsv_pkg::HUE_W-1:0]   m_hue,
    output logic [CHANNEL_BITS-1:0]     m_saturation,
    output logic [CHANNEL_BITS-1:0]     m_brightness,
    output logic                        m_achromatic
);
    import hsv_pkg::*;

    localparam int CB         = CHANNEL_BITS;
    localparam int DIV_STAGES = (CB > HUE_Q_W) ? CB : HUE_Q_W;
    localparam int CTL_W      = $bits(hsv_ctl_t);

    logic              en;

    logic              f_valid;
    logic [CB-1:0]     f_hi;
    logic [CB-1:0]     f_delta;
    logic [2*CB-1:0]   f_sat_num;
    logic [CB+HUE_Q_W-1:0] f_hue_num;
    hsv_ctl_t          f_ctl;

    logic              hd_valid;
    logic [DIV_STAGES-1:0] hd_quo;
    logic [CTL_W-1:0]  hd_side;
    logic              sd_valid;
    logic [DIV_STAGES-1:0] sd_quo;
    logic [CB-1:0]     sd_side;

    assign en      = !m_valid || m_ready;
    assign s_ready = en;

    hsv_front #(
        .CHANNEL_BITS(CB)
    ) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (s_valid),
        .red       (s_red),
        .green     (s_green),
        .blue      (s_blue),
        .out_valid (f_valid),
        .hi        (f_hi),
        .delta     (f_delta),
        .sat_num   (f_sat_num),
        .hue_num   (f_hue_num),
        .ctl       (f_ctl)
    );

    hsv_divider #(
        .NUM_W  (CB + HUE_Q_W),
        .DEN_W  (CB),
        .QUO_W  (DIV_STAGES),
        .SIDE_W (CTL_W)
    ) u_hue_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (f_valid),
        .num       (f_hue_num),
        .den       (f_delta),
        .side_in   (f_ctl),
        .out_valid (hd_valid),
        .quo       (hd_quo),
        .side_out  (hd_side)
    );

    hsv_divider #(
        .NUM_W  (2 * CB),
        .DEN_W  (CB),
        .QUO_W  (DIV_STAGES),
        .SIDE_W (CB)
    ) u_sat_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (f_valid),
        .num       (f_sat_num),
        .den       (f_hi),
        .side_in   (f_hi),
        .out_valid (sd_valid),
        .quo       (sd_quo),
        .side_out  (sd_side)
    );

    hsv_post #(
        .CHANNEL_BITS(CB)
    ) u_post (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .en         (en),
        .in_valid   (hd_valid && sd_valid),
        .hue_q      (hd_quo[HUE_Q_W-1:0]),
        .sat_q      (sd_quo[CB-1:0]),
        .hi         (sd_side),
        .ctl        (hsv_ctl_t'(hd_side)),
        .out_valid  (m_valid),
        .hue        (m_hue),
        .saturation (m_saturation),
        .brightness (m_brightness),
        .achromatic (m_achromatic)
    );

endmodule
